FILE: src/assert_macros.svh
// Assertion macros shared by the frame addresser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame addresser: same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame addresser: next-cycle check failed");

`endif

FILE: src/vdlfa_pkg.sv
// Types, constants and register map for the video delay/loop frame addresser.
`default_nettype none

package vdlfa_pkg;

   localparam int unsigned MAX_FRAMES_DEFAULT = 1024;
   localparam int unsigned SLOT_LIMIT         = 1024;

   localparam int unsigned INDEX_W    = 10;
   localparam int unsigned LEN_W      = 11;
   localparam int unsigned FPS_W      = 8;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned DIR_W      = 2;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned LOOP_W     = COUNT_W + 1;
   localparam int unsigned DIV_W      = 24;
   localparam int unsigned QUO_W      = 14;
   localparam int unsigned THR_W      = QUO_W + 1;
   localparam int unsigned STEP_CNT_W = $clog2(DIV_W + 1);
   localparam int unsigned MS_PER_SEC = 1000;

   // x / 1000 = (x / 8) / 125, the second step by reciprocal multiply; exact for x < 2^23
   localparam int unsigned DIV1000_PRE    = 3;
   localparam int unsigned DIV1000_IN_W   = 20;
   localparam int unsigned DIV1000_MUL_W  = 24;
   localparam int unsigned DIV1000_SHIFT  = 30;
   localparam int unsigned DIV1000_PROD_W = DIV1000_IN_W + DIV1000_MUL_W;
   localparam logic [DIV1000_MUL_W-1:0] DIV1000_MULT = 24'd8589935;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_FRAMES       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_RATE          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_MS            = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_MS             = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEEK_MS             = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_DIRECTION      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_FOLLOWS_PLAY = 3'd6;

   localparam logic [LEN_W-1:0]        BUFFER_FRAMES_RESET  = 11'd512;
   localparam logic [FPS_W-1:0]        FRAME_RATE_RESET     = 8'd30;
   localparam logic signed [MS_W-1:0]  DELAY_MS_RESET       = 16'sd0;
   localparam logic signed [MS_W-1:0]  LOOP_MS_RESET        = 16'sd10000;
   localparam logic signed [MS_W-1:0]  SEEK_MS_RESET        = 16'sd0;
   localparam logic signed [DIR_W-1:0] PLAY_DIRECTION_RESET = 2'sb01;

   localparam logic signed [DIR_W-1:0] DIR_STOP  = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_FWD   = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_BACK  = 2'sb11;
   localparam logic signed [DIR_W-1:0] DIR_BACK2 = 2'sb10;

   typedef enum logic [1:0] {
      SEQ_LAUNCH,
      SEQ_WAIT,
      SEQ_READY
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_DELAY_DIV,
      OP_DELAY_MOD,
      OP_LOOP_DIV,
      OP_SEEK_DIV,
      OP_SEEK_MOD,
      OP_PLAY_MOD,
      OP_WRITE_MOD
   } op_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [LEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [INDEX_W-1:0] write_index;
      logic [INDEX_W-1:0] read_index;
      logic               seek_taken;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: src/vdlfa_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module vdlfa_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  vdlfa_pkg::div_req_type    div_req,
   output vdlfa_pkg::div_rsp_type    div_rsp
);
   import vdlfa_pkg::*;

   logic                  active_ff;
   logic                  done_ff;
   logic [STEP_CNT_W-1:0] count_ff;
   logic [DIV_W-1:0]      shift_ff;
   logic [LEN_W-1:0]      rem_ff;
   logic [LEN_W-1:0]      divisor_ff;

   logic [LEN_W:0]        rem_w;
   logic [LEN_W:0]        rem_step;
   logic                  fits;

   always_comb begin
      rem_w    = {rem_ff, shift_ff[DIV_W-1]};
      fits     = rem_w >= {1'b0, divisor_ff};
      rem_step = fits ? (rem_w - {1'b0, divisor_ff}) : rem_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         done_ff <= active_ff && (count_ff == STEP_CNT_W'(1)) && !div_req.start;
         if (div_req.start) begin
            active_ff <= 1'b1;
            count_ff  <= STEP_CNT_W'(DIV_W);
         end else if (active_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == STEP_CNT_W'(1)) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         shift_ff   <= div_req.dividend;
         rem_ff     <= '0;
         divisor_ff <= div_req.divisor;
      end else if (active_ff) begin
         shift_ff <= {shift_ff[DIV_W-2:0], fits};
         rem_ff   <= rem_step[LEN_W-1:0];
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

FILE: src/video_delay_loop_frame_addresser_top.sv
// Top level of the video delay/loop frame addresser.
// Each accepted req transfer yields one rsp transfer carrying the slot to write, the slot
// to display and a seek flag; the result is registered in an output slot, and a second
// output slot keeps req open for one more transfer while rsp is stalled, so one frame
// tick per clock is sustained once the sequencer is ready and rsp is not stalled.
// Millisecond settings are turned into frame counts by a reciprocal multiply, and the
// counts and stored indexes are reduced modulo the ring length by a serial divider:
// three conversions and four reductions keep req_stall high after reset and after every
// csr write. Csr writes are taken at any time and restart that pass.
`default_nettype none
`include "assert_macros.svh"

module video_delay_loop_frame_addresser_top #(
   parameter int unsigned MAX_FRAMES = vdlfa_pkg::MAX_FRAMES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_frame_start,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [vdlfa_pkg::INDEX_W-1:0]            rsp_write_index,
   output logic [vdlfa_pkg::INDEX_W-1:0]            rsp_read_index,
   output logic                                     rsp_seek_taken,
   input  wire logic                                csr_wen,
   input  wire logic [vdlfa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [vdlfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import vdlfa_pkg::*;

   localparam int unsigned RING_CAP = (MAX_FRAMES < SLOT_LIMIT) ? MAX_FRAMES : SLOT_LIMIT;

   // configuration registers
   logic [LEN_W-1:0]        buffer_frames_ff;
   logic [FPS_W-1:0]        frame_rate_ff;
   logic signed [MS_W-1:0]  delay_ms_ff;
   logic signed [MS_W-1:0]  loop_ms_ff;
   logic signed [MS_W-1:0]  seek_ms_ff;
   logic signed [DIR_W-1:0] play_direction_ff;
   logic                    record_follows_ff;

   // frame-count sequencer
   seq_state_type           seq_state_ff, seq_state_in;
   op_type                  op_ff, op_in;
   div_req_type             div_req;
   div_rsp_type             div_rsp;
   logic                    div_op;
   logic                    step_done;
   logic [DIV1000_IN_W-1:0] scaled_ff;
   logic [DIV1000_PROD_W-1:0] recip_prod;

   // derived counts
   logic [QUO_W-1:0]        delay_q_ff;
   logic [INDEX_W-1:0]      delay_mod_ff;
   logic signed [THR_W-1:0] loop_thr_ff;
   logic [QUO_W-1:0]        seek_q_ff;
   logic [INDEX_W-1:0]      seek_mod_ff;

   // tick state
   logic [INDEX_W-1:0]      play_index_ff;
   logic [INDEX_W-1:0]      write_slot_ff;
   logic [INDEX_W-1:0]      play_cur_ff;
   logic [INDEX_W-1:0]      write_cur_ff;
   logic [COUNT_W-1:0]      loop_count_ff;

   // output queue
   logic                    rsp_valid_ff;
   logic                    skid_valid_ff;
   rsp_item_type            out_ff;
   rsp_item_type            skid_ff;
   rsp_item_type            new_item;

   logic [LEN_W-1:0]        ring_len;
   logic [FPS_W-1:0]        fps_eff;
   logic [INDEX_W-1:0]      dir_mod;
   logic [MS_W-1:0]         ms_sel;
   logic                    ms_neg;
   logic [MS_W-1:0]         ms_mag;
   logic [DIV_W-1:0]        product;
   logic                    round_up;
   logic                    delay_none;
   logic [DIV_W-1:0]        scaled;
   logic                    capture;
   logic [QUO_W-1:0]        quo;
   logic [THR_W-1:0]        quo_ext;
   logic [LEN_W-1:0]        seek_neg_mod;

   logic                    acc;
   logic                    take;
   logic                    tick;
   logic [LEN_W-1:0]        read_diff;
   logic [LEN_W-1:0]        read_wrap;
   logic [INDEX_W-1:0]      read_idx;
   logic [LEN_W-1:0]        step_sum;
   logic [LEN_W-1:0]        step_red;
   logic [LEN_W-1:0]        seek_sum;
   logic [LEN_W-1:0]        seek_red;
   logic [LEN_W-1:0]        wr_inc;
   logic [INDEX_W-1:0]      wr_next;
   logic [LOOP_W-1:0]       count_inc;
   logic signed [LOOP_W:0]  count_ext;
   logic signed [LOOP_W:0]  thr_ext;
   logic                    seek_hit;

   logic                    index_in_ring;
   logic                    counts_in_ring;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_frames_ff  <= BUFFER_FRAMES_RESET;
         frame_rate_ff     <= FRAME_RATE_RESET;
         delay_ms_ff       <= DELAY_MS_RESET;
         loop_ms_ff        <= LOOP_MS_RESET;
         seek_ms_ff        <= SEEK_MS_RESET;
         play_direction_ff <= PLAY_DIRECTION_RESET;
         record_follows_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_BUFFER_FRAMES:       buffer_frames_ff  <= csr_wdata[LEN_W-1:0];
            CSR_FRAME_RATE:          frame_rate_ff     <= csr_wdata[FPS_W-1:0];
            CSR_DELAY_MS:            delay_ms_ff       <= csr_wdata[MS_W-1:0];
            CSR_LOOP_MS:             loop_ms_ff        <= csr_wdata[MS_W-1:0];
            CSR_SEEK_MS:             seek_ms_ff        <= csr_wdata[MS_W-1:0];
            CSR_PLAY_DIRECTION:      play_direction_ff <= csr_wdata[DIR_W-1:0];
            CSR_RECORD_FOLLOWS_PLAY: record_follows_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (buffer_frames_ff == '0) begin
         ring_len = LEN_W'(1);
      end else if (buffer_frames_ff > LEN_W'(RING_CAP)) begin
         ring_len = LEN_W'(RING_CAP);
      end else begin
         ring_len = buffer_frames_ff;
      end
      fps_eff = (frame_rate_ff == '0) ? FPS_W'(1) : frame_rate_ff;
   end

   always_comb begin
      case (play_direction_ff)
         DIR_STOP:  dir_mod = '0;
         DIR_FWD:   dir_mod = (ring_len == LEN_W'(1)) ? '0 : INDEX_W'(1);
         DIR_BACK:  dir_mod = INDEX_W'(ring_len - LEN_W'(1));
         DIR_BACK2: dir_mod = (ring_len <= LEN_W'(2)) ? '0 : INDEX_W'(ring_len - LEN_W'(2));
         default:   dir_mod = '0;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset || csr_wen) begin
         seq_state_ff <= SEQ_LAUNCH;
         op_ff        <= OP_DELAY_DIV;
      end else begin
         seq_state_ff <= seq_state_in;
         op_ff        <= op_in;
      end
   end

   always_comb begin
      seq_state_in  = seq_state_ff;
      op_in         = op_ff;
      case (seq_state_ff)
         SEQ_LAUNCH: begin
            seq_state_in  = SEQ_WAIT;
         end
         SEQ_WAIT: begin
            if (step_done) begin
               if (op_ff == OP_WRITE_MOD) begin
                  seq_state_in = SEQ_READY;
               end else begin
                  op_in        = op_type'(op_ff + 1'b1);
                  seq_state_in = SEQ_LAUNCH;
               end
            end
         end
         SEQ_READY: ;
         default: seq_state_in = SEQ_LAUNCH;
      endcase
   end

   // ms * fps, plus 999 for ceiling (delay) or for floor toward minus infinity
   always_comb begin
      case (op_ff)
         OP_LOOP_DIV: ms_sel = loop_ms_ff;
         OP_SEEK_DIV: ms_sel = seek_ms_ff;
         default:     ms_sel = delay_ms_ff;
      endcase
      ms_neg     = ms_sel[MS_W-1];
      ms_mag     = ms_neg ? (~ms_sel + 1'b1) : ms_sel;
      product    = DIV_W'(ms_mag) * DIV_W'(fps_eff);
      round_up   = (op_ff == OP_DELAY_DIV) || ms_neg;
      delay_none = (op_ff == OP_DELAY_DIV) && (ms_neg || (ms_sel == '0));
      scaled     = delay_none ? '0
                              : product + (round_up ? DIV_W'(MS_PER_SEC - 1) : '0);
   end

   // scaled value registered in the launch cycle, divided by 1000 in the wait cycle
   always_ff @(posedge clock) begin
      scaled_ff <= scaled[DIV1000_PRE +: DIV1000_IN_W];
   end

   assign recip_prod = DIV1000_PROD_W'(scaled_ff) * DIV1000_PROD_W'(DIV1000_MULT);

   assign div_op    = op_ff inside {OP_DELAY_DIV, OP_LOOP_DIV, OP_SEEK_DIV};
   assign step_done = div_op || div_rsp.done;

   always_comb begin
      div_req.start = (seq_state_ff == SEQ_LAUNCH) && !div_op;
      case (op_ff)
         OP_DELAY_MOD: div_req.dividend = DIV_W'(delay_q_ff);
         OP_SEEK_MOD:  div_req.dividend = DIV_W'(seek_q_ff);
         OP_PLAY_MOD:  div_req.dividend = DIV_W'(play_index_ff);
         OP_WRITE_MOD: div_req.dividend = DIV_W'(write_slot_ff);
         default:      div_req.dividend = '0;
      endcase
      div_req.divisor = ring_len;
   end

   vdlfa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign capture      = (seq_state_ff == SEQ_WAIT) && step_done && !csr_wen;
   assign quo          = recip_prod[DIV1000_SHIFT +: QUO_W];
   assign quo_ext      = {1'b0, quo};
   assign seek_neg_mod = ring_len - div_rsp.remainder;

   always_ff @(posedge clock) begin
      if (capture) begin
         case (op_ff)
            OP_DELAY_DIV: delay_q_ff   <= quo;
            OP_DELAY_MOD: delay_mod_ff <= div_rsp.remainder[INDEX_W-1:0];
            OP_LOOP_DIV:  loop_thr_ff  <= loop_ms_ff[MS_W-1] ? (~quo_ext + 1'b1) : quo_ext;
            OP_SEEK_DIV:  seek_q_ff    <= quo;
            OP_SEEK_MOD:  seek_mod_ff  <= (seek_ms_ff[MS_W-1] && (div_rsp.remainder != '0))
                                          ? seek_neg_mod[INDEX_W-1:0]
                                          : div_rsp.remainder[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- tick path
   assign take = rsp_valid_ff && !rsp_stall;
   assign acc  = req_valid && !req_stall;
   assign tick = acc && req_frame_start;

   always_comb begin
      read_diff = {1'b0, play_cur_ff} - {1'b0, delay_mod_ff};
      read_wrap = read_diff + ring_len;
      read_idx  = (play_cur_ff >= delay_mod_ff) ? read_diff[INDEX_W-1:0]
                                                : read_wrap[INDEX_W-1:0];

      step_sum = {1'b0, play_cur_ff} + {1'b0, dir_mod};
      step_red = (step_sum >= ring_len) ? (step_sum - ring_len) : step_sum;
      seek_sum = step_red + {1'b0, seek_mod_ff};
      seek_red = (seek_sum >= ring_len) ? (seek_sum - ring_len) : seek_sum;

      wr_inc  = {1'b0, write_cur_ff} + LEN_W'(1);
      wr_next = (wr_inc >= ring_len) ? '0 : wr_inc[INDEX_W-1:0];

      count_inc = {1'b0, loop_count_ff} + LOOP_W'(1);
      count_ext = {1'b0, count_inc};
      thr_ext   = {{(LOOP_W + 1 - THR_W){loop_thr_ff[THR_W-1]}}, loop_thr_ff};
      seek_hit  = count_ext >= thr_ext;

      new_item.write_index = write_cur_ff;
      new_item.read_index  = read_idx;
      new_item.seek_taken  = req_frame_start && seek_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_index_ff <= '0;
         write_slot_ff <= '0;
         play_cur_ff   <= '0;
         write_cur_ff  <= '0;
         loop_count_ff <= '0;
      end else if (tick) begin
         if (seek_hit) begin
            play_index_ff <= seek_red[INDEX_W-1:0];
            play_cur_ff   <= seek_red[INDEX_W-1:0];
            write_slot_ff <= record_follows_ff ? seek_red[INDEX_W-1:0] : wr_next;
            write_cur_ff  <= record_follows_ff ? seek_red[INDEX_W-1:0] : wr_next;
            loop_count_ff <= '0;
         end else begin
            play_index_ff <= step_red[INDEX_W-1:0];
            play_cur_ff   <= step_red[INDEX_W-1:0];
            write_slot_ff <= wr_next;
            write_cur_ff  <= wr_next;
            loop_count_ff <= count_inc[COUNT_W-1:0];
         end
      end else if (capture && (op_ff == OP_PLAY_MOD)) begin
         play_cur_ff <= div_rsp.remainder[INDEX_W-1:0];
      end else if (capture && (op_ff == OP_WRITE_MOD)) begin
         write_cur_ff <= div_rsp.remainder[INDEX_W-1:0];
      end
   end

   // ---------------------------------------------------------------- output queue
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= acc;
         end
      end else if (acc) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (acc) begin
            out_ff <= new_item;
         end
      end else if (acc) begin
         skid_ff <= new_item;
      end
   end

   assign req_stall       = (seq_state_ff != SEQ_READY) || skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_index = out_ff.write_index;
   assign rsp_read_index  = out_ff.read_index;
   assign rsp_seek_taken  = out_ff.seek_taken;

   // ---------------------------------------------------------------- checks
   assign index_in_ring  = ({1'b0, play_cur_ff} < ring_len) && ({1'b0, write_cur_ff} < ring_len);
   assign counts_in_ring = ({1'b0, delay_mod_ff} < ring_len) && ({1'b0, seek_mod_ff} < ring_len);

   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_IMPLY(a_index_in_ring, clock, reset, seq_state_ff == SEQ_READY, index_in_ring)
   `ASSERT_IMPLY(a_counts_in_ring, clock, reset, seq_state_ff == SEQ_READY, counts_in_ring)
   `ASSERT_NEXT(a_csr_restarts, clock, reset, csr_wen, req_stall)

endmodule

`default_nettype wire

FILE: tb/tb_video_delay_loop_frame_addresser_top.sv
// Self-checking testbench for the video delay/loop frame addresser top level.
`timescale 1ns / 1ps

module tb_video_delay_loop_frame_addresser_top;
   import vdlfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_TICKS   = 1150;
   localparam longint MS_SEC     = longint'(MS_PER_SEC);
   localparam longint RING_CAP   = (MAX_FRAMES_DEFAULT < SLOT_LIMIT) ?
                                   longint'(MAX_FRAMES_DEFAULT) : longint'(SLOT_LIMIT);

   class frame_slot_tracker;
      logic [LEN_W-1:0]        ring_cfg   = BUFFER_FRAMES_RESET;
      logic [FPS_W-1:0]        rate_cfg   = FRAME_RATE_RESET;
      logic signed [MS_W-1:0]  delay_cfg  = DELAY_MS_RESET;
      logic signed [MS_W-1:0]  loop_cfg   = LOOP_MS_RESET;
      logic signed [MS_W-1:0]  seek_cfg   = SEEK_MS_RESET;
      logic signed [DIR_W-1:0] dir_cfg    = PLAY_DIRECTION_RESET;
      logic                    follow_cfg = 1'b0;

      logic [INDEX_W-1:0] play_pos = '0;
      logic [INDEX_W-1:0] wr_pos = '0;
      logic [COUNT_W-1:0] frames_in_loop = '0;

      rsp_item_type pending_reports[$];
      int errors = 0;
      int ticks = 0;
      int holds = 0;
      int seeks = 0;

      static function longint wrap_ring(longint v, longint len);
         longint r;
         r = v % len;
         if (r < 0) r += len;
         return r;
      endfunction

      static function longint frames_floor(logic signed [MS_W-1:0] ms, longint fps);
         longint prod;
         longint q;
         prod = longint'(ms) * fps;
         q = prod / MS_SEC;
         if (prod % MS_SEC != 0 && prod < 0) q--;
         return q;
      endfunction

      function void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BUFFER_FRAMES:       ring_cfg = data[LEN_W-1:0];
            CSR_FRAME_RATE:          rate_cfg = data[FPS_W-1:0];
            CSR_DELAY_MS:            delay_cfg = data;
            CSR_LOOP_MS:             loop_cfg = data;
            CSR_SEEK_MS:             seek_cfg = data;
            CSR_PLAY_DIRECTION:      dir_cfg = data[DIR_W-1:0];
            CSR_RECORD_FOLLOWS_PLAY: follow_cfg = data[0];
            default: ;
         endcase
      endfunction

      // accepted req transfer: predict its report and advance the ring state
      function void note_tick(logic frame_start);
         longint len;
         longint fps;
         longint play;
         longint wr;
         longint dly;
         longint n;
         rsp_item_type want;
         len = ring_cfg;
         if (len < 1) len = 1;
         if (len > RING_CAP) len = RING_CAP;
         fps = (rate_cfg == 0) ? 1 : longint'(rate_cfg);
         play = wrap_ring(longint'(play_pos), len);
         wr = wrap_ring(longint'(wr_pos), len);
         dly = (delay_cfg > 0) ? (longint'(delay_cfg) * fps + MS_SEC - 1) / MS_SEC : 0;
         want.write_index = INDEX_W'(wr);
         want.read_index = INDEX_W'(wrap_ring(play - dly, len));
         want.seek_taken = 1'b0;
         ticks++;
         if (frame_start) begin
            play = wrap_ring(play + longint'(dir_cfg), len);
            wr = wrap_ring(wr + 1, len);
            n = longint'(frames_in_loop) + 1;
            if (n >= frames_floor(loop_cfg, fps)) begin
               frames_in_loop = '0;
               play = wrap_ring(play + frames_floor(seek_cfg, fps), len);
               if (follow_cfg) wr = play;
               want.seek_taken = 1'b1;
               seeks++;
            end else begin
               frames_in_loop = COUNT_W'(n);
            end
            play_pos = INDEX_W'(play);
            wr_pos = INDEX_W'(wr);
         end else begin
            holds++;
         end
         pending_reports.push_back(want);
      endfunction

      function void check_report(logic [INDEX_W-1:0] wi, logic [INDEX_W-1:0] ri, logic st);
         rsp_item_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected rsp transfer, expected none, actual wi=%0d ri=%0d seek=%0b",
                     $time, wi, ri, st);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (wi !== want.write_index) begin
               $display("%0t: write_index expected %0d, actual %0d",
                        $time, want.write_index, wi);
               errors++;
            end
            if (ri !== want.read_index) begin
               $display("%0t: read_index expected %0d, actual %0d",
                        $time, want.read_index, ri);
               errors++;
            end
            if (st !== want.seek_taken) begin
               $display("%0t: seek_taken expected %0b, actual %0b",
                        $time, want.seek_taken, st);
               errors++;
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_frame_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [INDEX_W-1:0]    rsp_write_index;
   logic [INDEX_W-1:0]    rsp_read_index;
   logic                  rsp_seek_taken;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;
   int settings_done;
   int random_ticks;
   frame_slot_tracker tracker;

   video_delay_loop_frame_addresser_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_write_index (rsp_write_index),
      .rsp_read_index  (rsp_read_index),
      .rsp_seek_taken  (rsp_seek_taken),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_report(rsp_write_index, rsp_read_index, rsp_seek_taken);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < WATCHDOG_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
         $display("video_delay_loop_frame_addresser_top verification failed");
         $finish;
      end
   end

   task automatic send_tick(input logic fs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_start <= fs;
      do @(posedge clock); while (req_stall);
      tracker.note_tick(fs);
   endtask

   task automatic send_random_ticks(input int count);
      repeat (count) send_tick($urandom_range(99) < 80);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.apply_reg(idx, data);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] frames, rate, dly, lp, sk, dir,
                               follow);
      write_reg(CSR_BUFFER_FRAMES, frames);
      write_reg(CSR_FRAME_RATE, rate);
      write_reg(CSR_DELAY_MS, dly);
      write_reg(CSR_LOOP_MS, lp);
      write_reg(CSR_SEEK_MS, sk);
      write_reg(CSR_PLAY_DIRECTION, dir);
      write_reg(CSR_RECORD_FOLLOWS_PLAY, follow);
      csr_wen <= 1'b0;
      settings_done++;
   endtask

   task automatic pick_settings();
      logic [CSR_DATA_W-1:0] frames;
      logic [CSR_DATA_W-1:0] dly;
      logic [CSR_DATA_W-1:0] lp;
      logic [CSR_DATA_W-1:0] sk;
      case ($urandom_range(9))
         0:       frames = 16'($urandom_range(2047));
         1:       frames = 16'd1024;
         2:       frames = 16'($urandom_range(1));
         default: frames = 16'($urandom_range(2, 64));
      endcase
      case ($urandom_range(3))
         0:       dly = 16'($urandom);
         1:       dly = 16'(-int'($urandom_range(1, 500)));
         default: dly = 16'($urandom_range(3000));
      endcase
      case ($urandom_range(7))
         0:       lp = 16'($urandom);
         1:       lp = 16'(-int'($urandom_range(2000)));
         default: lp = 16'($urandom_range(250));
      endcase
      case ($urandom_range(3))
         0:       sk = 16'($urandom);
         default: sk = 16'(int'($urandom_range(8000)) - 4000);
      endcase
      program_regs(frames, 16'($urandom), dly, lp, sk, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int chunk;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frame_start = 1'b0;
      rsp_stall = 1'b0;
      csr_wen = 1'b0;
      csr_index = CSR_BUFFER_FRAMES;
      csr_wdata = '0;
      send_idle_pct = 35;
      recv_idle_pct = 81;
      quiet_cycles = 0;
      settings_done = 0;
      random_ticks = 0;
      tracker = new;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // single-slot ring, zero frame rate, loop ends every tick, step of minus two
      quiesce();
      program_regs(16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h8000, {14'd0, DIR_BACK2}, 16'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // oversized ring saturates, max rate, negative delay, zero loop, max seek
      quiesce();
      program_regs(16'h07FF, 16'h00FF, 16'h8000, 16'd0, 16'h7FFF, {14'd0, DIR_BACK}, 16'd0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);

      quiesce();
      program_regs(16'd1024, 16'd240, 16'd1000, 16'd100, 16'd500, {14'd0, DIR_FWD}, 16'd0);
      repeat (6) send_tick(1'b1);

      // ring shrinks below the stored indexes
      quiesce();
      program_regs(16'd3, 16'd240, 16'd5, 16'd7, 16'hFFF7, {14'd0, DIR_STOP}, 16'd1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);

      while (random_ticks < RANDOM_TICKS) begin
         if (random_ticks < RANDOM_TICKS / 3) begin
            send_idle_pct = 35;
            recv_idle_pct = 81;
         end else if (random_ticks < 2 * RANDOM_TICKS / 3) begin
            send_idle_pct = 81;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         quiesce();
         pick_settings();
         chunk = $urandom_range(60, 130);
         send_random_ticks(chunk);
         random_ticks += chunk;
      end

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d frame ticks (%0d report-only) and %0d loop-end seeks",
               tracker.ticks, tracker.holds, tracker.seeks);
      $display("across %0d register settings under three sender/receiver stall mixes",
               settings_done);
      if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
         $display("video_delay_loop_frame_addresser_top verification clean");
      end else begin
         $display("video_delay_loop_frame_addresser_top verification failed");
      end
      $finish;
   end

endmodule
